FILE: rtl/core/slr_pkg.sv
package slr_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int GAIN_W       = 16;
   localparam int STEP_W       = 21;
   localparam int PHASE_W      = 22;
   localparam int FRAC_W       = 16;
   localparam int GAIN_SHIFT   = 14;
   localparam int SAT_W        = 20;

   localparam int DEF_OUT_CHANNELS = 2;
   localparam int DEF_MAX_RUN      = 32;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = STEP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MONO_INPUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
   localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

   typedef struct packed {
      logic                mono_input;
      logic                bypass;
      logic [GAIN_W-1:0]   gain_q14;
      logic [STEP_W-1:0]   step_q16;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       restart;
   } frame_type;

   // clamp to the 16-bit sample range
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32767);
      lo = -SAT_W'(32768);
      if (v > hi) begin
         return 16'sh7FFF;
      end else if (v < lo) begin
         return 16'sh8000;
      end else begin
         return v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/core/slr_front.sv
module slr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  slr_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [slr_pkg::SAMPLE_W-1:0] req_in_left,
   input  logic signed [slr_pkg::SAMPLE_W-1:0] req_in_right,
   input  logic                            req_restart,
   output logic                            push,
   output slr_pkg::frame_type              push_data,
   input  logic                            queue_full
);
   import slr_pkg::*;

   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

   logic                     valid_ff, valid_in;
   logic signed [PROD_W-1:0] prod_l_ff, prod_l_in;
   logic signed [PROD_W-1:0] prod_r_ff, prod_r_in;
   logic                     restart_ff, restart_in;
   logic                     accept;
   logic signed [SAMPLE_W-1:0] gl, gr;

   // truncate toward zero by the Q14 shift, then clamp
   function automatic logic signed [SAMPLE_W-1:0] scale(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] t;
      t = {p[PROD_W-1], p};
      if (p[PROD_W-1]) begin
         t = t + (PROD_W+1)'((1 << GAIN_SHIFT) - 1);
      end
      return sat16(t[PROD_W:GAIN_SHIFT]);
   endfunction

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;

   always_comb begin
      gl = scale(prod_l_ff);
      gr = cfg.mono_input ? gl : scale(prod_r_ff);
      push_data.left    = gl;
      push_data.right   = gr;
      push_data.restart = restart_ff;
   end

   always_comb begin
      valid_in   = valid_ff;
      prod_l_in  = prod_l_ff;
      prod_r_in  = prod_r_ff;
      restart_in = restart_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in   = 1'b1;
         prod_l_in  = req_in_left * $signed({1'b0, cfg.gain_q14});
         prod_r_in  = req_in_right * $signed({1'b0, cfg.gain_q14});
         restart_in = req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_l_ff  <= prod_l_in;
      prod_r_ff  <= prod_r_in;
      restart_ff <= restart_in;
   end

endmodule

FILE: rtl/core/slr_queue.sv
module slr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  slr_pkg::frame_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output slr_pkg::frame_type pop_data
);
   import slr_pkg::*;

   frame_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full      = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/slr_back.sv
module slr_back #(
   parameter int OUT_CHANNELS = slr_pkg::DEF_OUT_CHANNELS,
   parameter int MAX_RUN      = slr_pkg::DEF_MAX_RUN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  slr_pkg::cfg_type                    cfg,
   input  logic                                q_not_empty,
   input  slr_pkg::frame_type                  q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [slr_pkg::SAMPLE_W-1:0] rsp_out_left,
   output logic signed [slr_pkg::SAMPLE_W-1:0] rsp_out_right,
   output logic                                rsp_last_of_run
);
   import slr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_RUN + 1);
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int MUL_W  = 2 * DIFF_W;
   localparam int NUM_W  = MUL_W + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic                       have_prev_ff, have_prev_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_W-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic signed [MUL_W-1:0]    prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       hist;
   logic [PHASE_W-1:0]         start_phase;
   logic [PHASE_W-1:0]         next_phase;
   logic signed [DIFF_W-1:0]   diff_l, diff_r, frac;
   logic                       more;

   // prev * 2^16 + product, truncated toward zero by 16 and clamped
   function automatic logic signed [SAMPLE_W-1:0] blend(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [MUL_W-1:0]    p
   );
      logic signed [NUM_W-1:0] num;
      num = $signed({{(NUM_W-SAMPLE_W-FRAC_W){a[SAMPLE_W-1]}}, a, {FRAC_W{1'b0}}})
            + $signed({p[MUL_W-1], p});
      if (num[NUM_W-1]) begin
         num = num + NUM_W'((1 << FRAC_W) - 1);
      end
      return sat16(SAT_W'($signed(num[NUM_W-1:FRAC_W])));
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty && out_free;

   assign hist        = have_prev_ff && !q_data.restart;
   assign start_phase = q_data.restart ? '0 : phase_ff;
   assign next_phase  = phase_ff + PHASE_W'(cfg.step_q16);
   assign more        = (phase_ff < PHASE_ONE) && (cnt_ff < CNT_W'(MAX_RUN));

   assign diff_l = $signed({cur_l_ff[SAMPLE_W-1], cur_l_ff})
                   - $signed({prev_l_ff[SAMPLE_W-1], prev_l_ff});
   assign diff_r = $signed({cur_r_ff[SAMPLE_W-1], cur_r_ff})
                   - $signed({prev_r_ff[SAMPLE_W-1], prev_r_ff});
   assign frac   = $signed({1'b0, phase_ff[FRAC_W-1:0]});

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      have_prev_in = have_prev_ff;
      cnt_in       = cnt_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (cfg.bypass) begin
                  have_prev_in = 1'b0;
                  phase_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_l_in     = q_data.left;
                  rsp_r_in     = q_data.right;
                  rsp_last_in  = 1'b1;
               end else if (!hist) begin
                  // first frame of a stream: store history only
                  prev_l_in    = q_data.left;
                  prev_r_in    = q_data.right;
                  have_prev_in = 1'b1;
                  phase_in     = start_phase;
               end else begin
                  cur_l_in = q_data.left;
                  cur_r_in = q_data.right;
                  phase_in = start_phase;
                  cnt_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (more) begin
               prod_l_in = diff_l * frac;
               prod_r_in = diff_r * frac;
               last_in   = (next_phase >= PHASE_ONE) || (cnt_ff == CNT_W'(MAX_RUN - 1));
               phase_in  = next_phase;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = ST_WRITE;
            end else begin
               // close the run; a run cut by the limit restarts at phase zero
               phase_in  = (phase_ff >= PHASE_ONE) ? phase_ff - PHASE_ONE : '0;
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = blend(prev_l_ff, prod_l_ff);
               rsp_r_in     = blend(prev_r_ff, prod_r_ff);
               rsp_last_in  = last_ff;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         have_prev_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         have_prev_ff <= have_prev_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_l_ff   <= prev_l_in;
      prev_r_ff   <= prev_r_in;
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      last_ff     <= last_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_left    = rsp_l_ff;
   assign rsp_out_right   = (OUT_CHANNELS > 1) ? rsp_r_ff : '0;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

FILE: rtl/core/stream_linear_resampler_unit.sv
// Linear-interpolation sample rate converter for 16-bit stereo frames. The
// front end scales each request by the Q2.14 gain (a registered multiply,
// then clamp and mono mapping) and parks it in a two-entry queue, so requests
// keep flowing while the back end works. The back end takes a new frame from
// the queue only in its idle state, where a history-only or bypass frame is
// handled in full; every output frame of an interpolated frame goes through
// one interpolation multiply and one output register write. A response stall
// holds the back end in place; the queue then fills and stalls the request
// side. Configuration registers are to be written only while the block is
// idle, which it does not enforce; a write takes effect on the next frame.
module stream_linear_resampler_unit #(
   parameter int OUT_CHANNELS = slr_pkg::DEF_OUT_CHANNELS,
   parameter int MAX_RUN      = slr_pkg::DEF_MAX_RUN
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]   req_in_left,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]   req_in_right,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [slr_pkg::SAMPLE_W-1:0]   rsp_out_left,
   output logic signed [slr_pkg::SAMPLE_W-1:0]   rsp_out_right,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [slr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]        csr_data
);
   import slr_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push, queue_full, q_pop, q_not_empty;
   frame_type push_data, q_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MONO_INPUT: cfg_in.mono_input = csr_data[0];
            CSR_BYPASS:     cfg_in.bypass     = csr_data[0];
            CSR_GAIN:       cfg_in.gain_q14   = csr_data[GAIN_W-1:0];
            CSR_STEP:       cfg_in.step_q16   = csr_data[STEP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mono_input <= 1'b0;
         cfg_ff.bypass     <= 1'b0;
         cfg_ff.gain_q14   <= GAIN_RESET;
         cfg_ff.step_q16   <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_left  (req_in_left),
      .req_in_right (req_in_right),
      .req_restart  (req_restart),
      .push         (push),
      .push_data    (push_data),
      .queue_full   (queue_full)
   );

   slr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   slr_back #(
      .OUT_CHANNELS (OUT_CHANNELS),
      .MAX_RUN      (MAX_RUN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_not_empty     (q_not_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_left    (rsp_out_left),
      .rsp_out_right   (rsp_out_right),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
